// File: sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// shared constants, codes and control types for the sorted key table
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

    localparam int SKT_TABLE_DEPTH = 16384;
    localparam int SKT_KEY_BYTES   = 6;

    // fixed field widths
    localparam int ACT_W = 2;
    localparam int KEY_W = 48;
    localparam int STS_W = 2;
    localparam int POS_W = 15;

    // action codes
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STS_W-1:0] ST_CLEARED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PROBE,
        S_CMP,
        S_FINISH
    } skt_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic probe;
        logic compare;
        logic miss;
        logic load_out;
    } skt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_search;
        logic range_ok;
        logic hit;
    } skt_sts_t;

endpackage

`default_nettype wire

// File: sv/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// sequencer for append, clear and binary search, owns both handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire skt_sts_t sts,
    output skt_cmd_t      cmd
);

    skt_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.is_search ? S_PROBE : S_FINISH;
            end
            S_PROBE:
            begin
                if (sts.range_ok)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = sts.hit ? S_FINISH : S_PROBE;
            end
            S_FINISH:
            begin
                // wait until the output word slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/skt_dp.sv
// ----------------------------------------------------------------------------
// skt_dp
// key table datapath: entry count, search bounds, probe compare, result regs
// ----------------------------------------------------------------------------
`default_nettype none

module skt_dp
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = SKT_TABLE_DEPTH,
    parameter int KEY_BYTES   = SKT_KEY_BYTES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire skt_cmd_t         cmd,
    output skt_sts_t              sts,
    input  wire logic [ACT_W-1:0] action,
    input  wire logic [KEY_W-1:0] key,
    output logic      [STS_W-1:0] status,
    output logic      [POS_W-1:0] position
);

    localparam int KW     = (8 * KEY_BYTES > KEY_W) ? KEY_W : 8 * KEY_BYTES;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic [ACT_W-1:0]  act_reg;
    logic [KW-1:0]     key_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hi_reg;      // exclusive upper bound
    logic [ADDR_W-1:0] mid_reg;
    logic [STS_W-1:0]  pend_sts_reg;
    logic [CNT_W-1:0]  pend_pos_reg;
    logic [STS_W-1:0]  status_reg;
    logic [POS_W-1:0]  position_reg;

    logic [CNT_W:0]    mid_sum;
    logic [ADDR_W-1:0] mid;
    logic [KW-1:0]     rdata;
    logic              full;
    logic              ram_we;

    // floor((lo + hi_incl) / 2) with hi_incl = hi - 1, only used while lo < hi
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid     = ADDR_W'(mid_sum >> 1);
    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign ram_we  = cmd.exec && (act_reg == ACT_APPEND) && !full;

    assign sts.is_search = (act_reg == ACT_SEARCH);
    assign sts.range_ok  = (lo_reg < hi_reg);
    assign sts.hit       = (rdata == key_reg);

    skt_ram #(
        .WIDTH (KW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(count_reg)),
        .wdata (key_reg),
        .re    (cmd.probe),
        .raddr (mid),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (ram_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (act_reg == ACT_CLEAR)
            begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg <= action;
            key_reg <= key[KW-1:0];
        end

        if (cmd.exec)
        begin
            case (act_reg)
                ACT_APPEND:
                begin
                    if (!full)
                    begin
                        pend_sts_reg <= ST_DONE;
                        pend_pos_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        pend_sts_reg <= ST_FULL;
                        pend_pos_reg <= '0;
                    end
                end
                ACT_SEARCH:
                begin
                    lo_reg <= '0;
                    hi_reg <= count_reg;
                end
                ACT_CLEAR:
                begin
                    pend_sts_reg <= ST_CLEARED;
                    pend_pos_reg <= '0;
                end
                default:
                begin
                    pend_sts_reg <= ST_MISS;
                    pend_pos_reg <= '0;
                end
            endcase
        end

        if (cmd.probe)
        begin
            mid_reg <= mid;
        end

        if (cmd.miss)
        begin
            pend_sts_reg <= ST_MISS;
            pend_pos_reg <= '0;
        end

        if (cmd.compare)
        begin
            if (sts.hit)
            begin
                pend_sts_reg <= ST_DONE;
                pend_pos_reg <= CNT_W'(mid_reg) + 1'b1;
            end
            else if (rdata > key_reg)
            begin
                hi_reg <= CNT_W'(mid_reg);
            end
            else
            begin
                lo_reg <= CNT_W'(mid_reg) + 1'b1;
            end
        end

        if (cmd.load_out)
        begin
            status_reg   <= pend_sts_reg;
            position_reg <= POS_W'(pend_pos_reg);
        end
    end

    assign status   = status_reg;
    assign position = position_reg;

endmodule

`default_nettype wire

// File: sv/sorted_key_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_key_table_binary_search
// sorted key table with append, clear and binary search lookup
// ----------------------------------------------------------------------------
// append, clear: exec, then finish registers the result word; input is ready again as it posts
// search: exec, then P probe and compare steps, then finish; P probes <= floor(log2(n)) + 1
//   each probe is one registered ram read then one key compare; one word is in
//   flight at a time
// the result register lets a new word in while the last result waits
// reset clears the entry count and both handshakes; table contents are kept
`default_nettype none

module sorted_key_table_binary_search
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = SKT_TABLE_DEPTH,
    parameter int KEY_BYTES   = SKT_KEY_BYTES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [ACT_W-1:0] action,
    input  wire logic [KEY_W-1:0] key,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [STS_W-1:0] status,
    output logic      [POS_W-1:0] position
);

    skt_cmd_t cmd;
    skt_sts_t sts;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    skt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .action   (action),
        .key      (key),
        .status   (status),
        .position (position)
    );

    // one word in flight: an accepted word blocks the input on the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // a new result is posted only as the sequencer returns to idle
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted while sequencer busy");

    // only a done status carries a position
    a_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_MISS || status == ST_FULL || status == ST_CLEARED))
        |-> (position == '0))
        else $error("nonzero position on a miss, full or clear result");

endmodule

`default_nettype wire
